/* hw/rtl/zoom_position_to_field_of_view_defines.svh */
// Assertion macros for the zoom position to field of view block.
// Included by the top level only; no other dependencies.
`ifndef ZOOM_POSITION_TO_FIELD_OF_VIEW_DEFINES_SVH
`define ZOOM_POSITION_TO_FIELD_OF_VIEW_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define ZPF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("zpf assertion failed");

// Next-cycle implication, not masked by reset.
`define ZPF_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("zpf assertion failed");

`endif

/* hw/rtl/zpf_pkg.sv */
// Shared constants, register map and arctangent table for the zoom block.
// No dependencies.
`timescale 1ns / 1ps
package zpf_pkg;

    localparam int POLY_W  = 46;
    localparam int FOCAL_W = 24;
    localparam int RATIO_W = 24;
    localparam int FOV_W   = 18;

    localparam logic [2:0] REG_SENSOR_WIDTH = 3'd0;
    localparam logic [2:0] REG_CONST_COEF   = 3'd1;
    localparam logic [2:0] REG_LIN_COEF     = 3'd2;
    localparam logic [2:0] REG_QUAD_COEF    = 3'd3;
    localparam logic [2:0] REG_REF_FOCAL    = 3'd4;
    localparam logic [2:0] REG_MAX_POSITION = 3'd5;

    // atan(2^-i) in units of 2^-30 rad
    function automatic logic [31:0] atan_val(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000008;
            5'd28: r = 32'h00000004;
            5'd29: r = 32'h00000002;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/zoom_position_to_field_of_view.sv */
// Top level: APB register file, polynomial, CORDIC and two dividers.
// Depends on zpf_pkg, zpf_poly, zpf_cordic, zpf_div and the defines header.
//
// Usage:
//   Input channel s_valid/s_ready carries one zoom position per item; the
//   result channel m_valid/m_ready carries focal length, zoom ratio, field
//   of view and the range error flag for that item, in order.
//   Throughput: one item per cycle while the receiver accepts results. The
//   chain is polynomial, CORDIC, focal divider, ratio divider and output
//   register.
//   The dividers resolve one quotient bit per stage.
//   The whole pipeline advances on one enable; when the receiver stalls
//   with a result held, every stage holds and s_ready drops, so nothing is
//   lost or repeated. Empty slots move up while the output is free.
//   Reset clears all valid bits and loads the register defaults.
//   The user must write registers only while the pipeline is empty; no logic enforces it.
`timescale 1ns / 1ps
`include "zoom_position_to_field_of_view_defines.svh"
module zoom_position_to_field_of_view #(
    parameter int ATAN_STEPS = 18
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [4:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [15:0]                        s_zoom_position,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [zpf_pkg::FOCAL_W-1:0]        m_focal_length,
    output logic [zpf_pkg::RATIO_W-1:0]        m_zoom_ratio,
    output logic [zpf_pkg::FOV_W-1:0]          m_field_of_view,
    output logic                               m_range_error
);
    import zpf_pkg::*;

    localparam int FTAG_W = 1 + FOV_W;
    localparam int RTAG_W = 1 + FOV_W + FOCAL_W;

    // register file
    logic [13:0]        sensor_width_reg;
    logic signed [31:0] const_coef_reg, lin_coef_reg, quad_coef_reg;
    logic [23:0]        ref_focal_reg;
    logic [15:0]        max_position_reg;
    logic               wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_width_reg <= 14'd1920;
            const_coef_reg   <= 32'sd1064292896;
            lin_coef_reg     <= -32'sd108791522;
            quad_coef_reg    <= 32'sd2886218;
            ref_focal_reg    <= 24'd495884;
            max_position_reg <= 16'd31424;
        end else if (wr) begin
            case (paddr[4:2])
                REG_SENSOR_WIDTH: sensor_width_reg <= pwdata[13:0];
                REG_CONST_COEF:   const_coef_reg   <= $signed(pwdata);
                REG_LIN_COEF:     lin_coef_reg     <= $signed(pwdata);
                REG_QUAD_COEF:    quad_coef_reg    <= $signed(pwdata);
                REG_REF_FOCAL:    ref_focal_reg    <= pwdata[23:0];
                REG_MAX_POSITION: max_position_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SENSOR_WIDTH: prdata = {18'd0, sensor_width_reg};
            REG_CONST_COEF:   prdata = const_coef_reg;
            REG_LIN_COEF:     prdata = lin_coef_reg;
            REG_QUAD_COEF:    prdata = quad_coef_reg;
            REG_REF_FOCAL:    prdata = {8'd0, ref_focal_reg};
            REG_MAX_POSITION: prdata = {16'd0, max_position_reg};
            default:          prdata = '0;
        endcase
    end

    // global pipeline enable
    logic en;
    logic out_valid_reg;
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // polynomial
    logic                     pl_valid, pl_err;
    logic signed [POLY_W-1:0] pl_poly;

    zpf_poly u_poly (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_valid),
        .position     (s_zoom_position),
        .max_position (max_position_reg),
        .const_coef   (const_coef_reg),
        .lin_coef     (lin_coef_reg),
        .quad_coef    (quad_coef_reg),
        .out_valid    (pl_valid),
        .poly         (pl_poly),
        .err          (pl_err)
    );

    // arctangent; poly and error ride along
    logic                     cd_valid;
    logic [FOV_W-1:0]         cd_fov;
    logic [POLY_W:0]          cd_tag;

    zpf_cordic #(
        .STEPS (ATAN_STEPS),
        .TAG_W (POLY_W + 1)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pl_valid),
        .y_in      (pl_poly),
        .tag_in    ({pl_err, pl_poly}),
        .out_valid (cd_valid),
        .fov       (cd_fov),
        .tag_out   (cd_tag)
    );

    // focal = round(width * 2^38 / poly)
    logic              cd_err;
    logic [44:0]       fden;
    logic [52:0]       fnum;

    assign cd_err = cd_tag[POLY_W];
    assign fden   = cd_err ? 45'd0 : cd_tag[44:0];
    assign fnum   = 53'({sensor_width_reg, 38'd0}) + 53'(fden >> 1);

    logic               fd_valid;
    logic [FOCAL_W-1:0] fd_quot;
    logic [FTAG_W-1:0]  fd_tag;

    zpf_div #(
        .NUM_W (53),
        .DEN_W (45),
        .Q_W   (FOCAL_W),
        .TAG_W (FTAG_W)
    ) u_focal_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cd_valid),
        .num       (fnum),
        .den       (fden),
        .tag_in    ({cd_err, cd_fov}),
        .out_valid (fd_valid),
        .quot      (fd_quot),
        .tag_out   (fd_tag)
    );

    // ratio = round(focal * 2^16 / ref_focal); zero divisor saturates
    logic [40:0] rnum;
    assign rnum = 41'({fd_quot, 16'd0}) + 41'(ref_focal_reg >> 1);

    logic               rd_valid;
    logic [RATIO_W-1:0] rd_quot;
    logic [RTAG_W-1:0]  rd_tag;

    zpf_div #(
        .NUM_W (41),
        .DEN_W (24),
        .Q_W   (RATIO_W),
        .TAG_W (RTAG_W)
    ) u_ratio_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fd_valid),
        .num       (rnum),
        .den       (ref_focal_reg),
        .tag_in    ({fd_tag, fd_quot}),
        .out_valid (rd_valid),
        .quot      (rd_quot),
        .tag_out   (rd_tag)
    );

    // output register; range error forces full scale
    logic               r_err;
    logic [FOCAL_W-1:0] focal_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [FOV_W-1:0]   fov_reg;
    logic               err_reg;

    assign r_err = rd_tag[RTAG_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= rd_valid;
        end
        if (en) begin
            err_reg   <= r_err;
            focal_reg <= r_err ? '1 : rd_tag[FOCAL_W-1:0];
            ratio_reg <= r_err ? '1 : rd_quot;
            fov_reg   <= r_err ? '1 : rd_tag[FOCAL_W +: FOV_W];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_focal_length  = focal_reg;
    assign m_zoom_ratio    = ratio_reg;
    assign m_field_of_view = fov_reg;
    assign m_range_error   = err_reg;

    `ZPF_ASSERT_IMPL(a_err_full_scale, aclk, aresetn, m_valid && m_range_error, m_focal_length == 24'hFFFFFF && m_zoom_ratio == 24'hFFFFFF && m_field_of_view == 18'h3FFFF)
    `ZPF_ASSERT_IMPL(a_ready_tracks_out, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready))
    `ZPF_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)
endmodule

/* hw/rtl/zpf_poly.sv */
// Four-stage clamp and calibration polynomial.
// Depends on zpf_pkg.
`timescale 1ns / 1ps
module zpf_poly (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [15:0]                       position,
    input  logic [15:0]                       max_position,
    input  logic signed [31:0]                const_coef,
    input  logic signed [31:0]                lin_coef,
    input  logic signed [31:0]                quad_coef,
    output logic                              out_valid,
    output logic signed [zpf_pkg::POLY_W-1:0] poly,
    output logic                              err
);
    import zpf_pkg::*;

    logic [3:0]               v_reg;
    logic [15:0]              p_reg;
    logic signed [47:0]       lin_prod_reg, lin_prod_next;
    logic [31:0]              pp_reg;
    logic signed [63:0]       quad_prod_reg, quad_prod_next;
    logic signed [37:0]       lin_sh_reg;
    logic signed [POLY_W-1:0] poly_reg, poly_next;
    logic                     err_reg;

    always_comb begin
        lin_prod_next  = lin_coef * $signed({1'b0, p_reg});
        quad_prod_next = quad_coef * $signed({1'b0, pp_reg});
        poly_next = POLY_W'(const_coef) + POLY_W'(lin_sh_reg)
                  + POLY_W'(quad_prod_reg >>> 20);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
        if (en) begin
            p_reg         <= (position > max_position) ? max_position : position;
            lin_prod_reg  <= lin_prod_next;
            pp_reg        <= p_reg * p_reg;
            quad_prod_reg <= quad_prod_next;
            lin_sh_reg    <= 38'(lin_prod_reg >>> 10);
            poly_reg      <= poly_next;
            err_reg       <= (poly_next <= 0);
        end
    end

    assign out_valid = v_reg[3];
    assign poly      = poly_reg;
    assign err       = err_reg;
endmodule

/* hw/rtl/zpf_cordic.sv */
// Pipelined vectoring CORDIC: one stage per step, then rounding to 2^-16 rad.
// Depends on zpf_pkg.
`timescale 1ns / 1ps
module zpf_cordic #(
    parameter int STEPS = 18,
    parameter int TAG_W = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [zpf_pkg::POLY_W-1:0] y_in,
    input  logic [TAG_W-1:0]                  tag_in,
    output logic                              out_valid,
    output logic [zpf_pkg::FOV_W-1:0]         fov,
    output logic [TAG_W-1:0]                  tag_out
);
    import zpf_pkg::*;

    localparam int XY_W = 48;

    logic signed [XY_W-1:0] x_reg [0:STEPS];
    logic signed [XY_W-1:0] y_reg [0:STEPS];
    logic signed [31:0]     z_reg [0:STEPS];
    logic [TAG_W-1:0]       t_reg [0:STEPS];
    logic [STEPS:0]         v_reg;
    logic [FOV_W-1:0]       fov_reg, fov_next;
    logic [TAG_W-1:0]       tag_reg;
    logic                   vout_reg;
    logic [32:0]            zr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            x_reg[0] <= XY_W'(64'sd2147483648);
            y_reg[0] <= XY_W'(y_in);
            z_reg[0] <= '0;
            t_reg[0] <= tag_in;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                t_reg[i+1] <= t_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed(atan_val(5'(i)));
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed(atan_val(5'(i)));
                end
            end
        end
    end

    // 2*z rounded to 2^-16 rad, clipped at both ends
    always_comb begin
        zr = 33'($unsigned(z_reg[STEPS])) + 33'd4096;
        if (z_reg[STEPS] < 0) begin
            fov_next = '0;
        end else if (zr[32:13] > 20'h3FFFF) begin
            fov_next = '1;
        end else begin
            fov_next = zr[30:13];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vout_reg <= 1'b0;
        end else if (en) begin
            vout_reg <= v_reg[STEPS];
        end
        if (en) begin
            fov_reg <= fov_next;
            tag_reg <= t_reg[STEPS];
        end
    end

    assign out_valid = vout_reg;
    assign fov       = fov_reg;
    assign tag_out   = tag_reg;
endmodule

/* hw/rtl/zpf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Depends on zpf_pkg.
`timescale 1ns / 1ps
module zpf_div #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 45,
    parameter int Q_W   = 24,
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [Q_W-1:0]   quot,
    output logic [TAG_W-1:0] tag_out
);
    import zpf_pkg::*;

    localparam int REM_W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

    logic [REM_W-1:0] rem_reg [0:Q_W];
    logic [DEN_W-1:0] den_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic [TAG_W-1:0] t_reg   [0:Q_W];
    logic [Q_W:0]     sat_reg;
    logic [Q_W:0]     v_reg;

    // quotient of 2^Q_W or more saturates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            rem_reg[0] <= REM_W'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            t_reg[0]   <= tag_in;
            sat_reg[0] <= REM_W'(num) >= (REM_W'(den) << Q_W);
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_bit
        localparam int B = Q_W - k;
        logic [REM_W-1:0] dsh;
        logic             ge;
        assign dsh = REM_W'(den_reg[k-1]) << B;
        assign ge  = rem_reg[k-1] >= dsh;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
            if (en) begin
                rem_reg[k] <= ge ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (Q_W'(ge) << B);
                t_reg[k]   <= t_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign quot      = sat_reg[Q_W] ? '1 : q_reg[Q_W];
    assign tag_out   = t_reg[Q_W];
endmodule
